/* rtl/ifrt_pkg.sv */
// Package: payload types, event codes and constants of the fragment tracker.
`timescale 1ns / 1ps
package ifrt_pkg;

    localparam logic [7:0] TIMEOUT_RESET = 8'd5;

    typedef enum logic [2:0] {
        EV_STORED        = 3'd0,
        EV_COMPLETE      = 3'd1,
        EV_DROPPED       = 3'd2,
        EV_TIME_EXCEEDED = 3'd3,
        EV_EXPIRED       = 3'd4
    } event_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] ident;
        logic [12:0] frag_offset;
        logic        more_fragments;
        logic [15:0] total_length;
        logic [3:0]  header_words;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [5:0]  slot;
        logic [15:0] payload_length;
        logic [5:0]  header_bytes;
        logic        last;
    } out_item_t;

    // One stored fragment entry.
    typedef struct packed {
        logic [12:0] offset;
        logic        more;
        logic [15:0] length;
    } frag_t;

    // Per-slot record kept in the slot memory.
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] ident;
        logic [3:0]  hdr_words;
        logic [7:0]  start_tick;
        logic        first_zero;
    } slot_rec_t;

endpackage

/* rtl/ip_fragment_reassembly_tracker_top.sv */
// Top level: IPv4 fragment reassembly tracker with slot table and fragment memory.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries fragments (operation 0)
//   or timer ticks (operation 1). Output channel (out_valid/out_stall/out_data)
//   carries result transfers; the final one of each input has last set.
//   cfg_we/cfg_data write timeout_ticks; write only while idle.
// Sequence:
//   A fragment takes a slot search (one memory read per slot), a decide
//   step, then a sorted insert that shifts the list one entry at a time
//   from the tail (up to MAX_FRAGS read/write pairs), then a completion
//   walk of one entry per cycle over the list. The fragment memory has a
//   single read port. A tick checks one slot per cycle, and holds while a
//   waiting result stays stalled.
// Reset:
//   Valid bits and fragment counts clear at once; the tick counter clears and
//   timeout_ticks returns to 5. Memories are not cleared.
// Stall:
//   A result sits in the output register until taken; the sequencer holds when a new
//   result waits on a stalled one. in_stall is high whenever an item is at work.
module ip_fragment_reassembly_tracker_top
    import ifrt_pkg::*;
#(
    parameter int NUM_SLOTS = 10,
    parameter int MAX_FRAGS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data
);
    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SCW   = $clog2(NUM_SLOTS + 1);
    localparam int CW    = $clog2(MAX_FRAGS + 1);
    localparam int DEPTH = NUM_SLOTS * MAX_FRAGS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SCAN   = 11'b00000000010,
        S_DECIDE = 11'b00000000100,
        S_SHRD   = 11'b00000001000,
        S_SHWR   = 11'b00000010000,
        S_WALKRD = 11'b00000100000,
        S_WALK   = 11'b00001000000,
        S_EMIT   = 11'b00010000000,
        S_TICK   = 11'b00100000000,
        S_TEMIT  = 11'b01000000000,
        S_HEAD   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // slot records: a small synchronous memory read by the scan
    slot_rec_t slot_mem [NUM_SLOTS];
    slot_rec_t rec_rd;
    logic [SW-1:0] rec_raddr;
    logic rec_we;
    logic [SW-1:0] rec_waddr;
    slot_rec_t rec_wdata;

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            slot_mem[rec_waddr] <= rec_wdata;
        end
        rec_rd <= slot_mem[rec_raddr];
    end

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0] cnt_reg [NUM_SLOTS];
    logic [CW-1:0] cnt_wval;
    logic cnt_we;
    logic [7:0] tick_reg, tick_next;
    logic [7:0] timeout_reg;

    in_item_t item_reg, item_next;
    logic [SCW-1:0] idx_reg, idx_next;        // slot being read
    logic [SCW-1:0] chk_reg, chk_next;        // slot whose record is in rec_rd
    logic chk_v_reg, chk_v_next;
    logic hit_reg, hit_next;
    logic [SW-1:0] hslot_reg, hslot_next;
    slot_rec_t hrec_reg, hrec_next;
    logic [CW-1:0] pos_reg, pos_next;         // shift cursor
    logic [CW-1:0] wi_reg, wi_next;           // walk cursor
    logic [15:0] run_reg, run_next;
    logic [15:0] sum_reg, sum_next;
    logic done_reg, done_next;
    logic [CW-1:0] n_reg, n_next;
    logic pend_reg, pend_next;                // held result pending (tick); complete flag in the walk
    out_item_t pend_item_reg, pend_item_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic f_we;
    logic [AW-1:0] f_waddr, f_raddr;
    frag_t f_wdata, f_rd;

    ifrt_frag_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rd)
    );

    function automatic logic [AW-1:0] faddr(input logic [SW-1:0] s, input logic [CW-1:0] i);
        logic [AW+CW-1:0] a;
        a = (AW+CW)'(s) * (AW+CW)'(MAX_FRAGS) + (AW+CW)'(i);
        return a[AW-1:0];
    endfunction

    logic [15:0] plen;
    assign plen = item_reg.total_length - {10'd0, item_reg.header_words, 2'b00};

    logic key_eq;
    assign key_eq = rec_rd.src == item_reg.src_addr && rec_rd.dst == item_reg.dst_addr
                    && rec_rd.ident == item_reg.ident;

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    logic [SW-1:0] chk_s;
    assign chk_s = chk_reg[SW-1:0];
    logic [CW-1:0] hcnt;
    assign hcnt = cnt_reg[hslot_reg];

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        chk_next       = chk_reg;
        chk_v_next     = 1'b0;
        hit_next       = hit_reg;
        hslot_next     = hslot_reg;
        hrec_next      = hrec_reg;
        pos_next       = pos_reg;
        wi_next        = wi_reg;
        run_next       = run_reg;
        sum_next       = sum_reg;
        done_next      = done_reg;
        n_next         = n_reg;
        pend_next      = pend_reg;
        pend_item_next = pend_item_reg;
        valid_next     = valid_reg;
        tick_next      = tick_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        rec_raddr      = idx_reg[SW-1:0];
        rec_we         = 1'b0;
        rec_waddr      = hslot_reg;
        rec_wdata      = hrec_reg;
        cnt_we         = 1'b0;
        cnt_wval       = hcnt;
        f_we           = 1'b0;
        f_waddr        = faddr(hslot_reg, pos_reg);
        f_wdata        = '0;
        f_raddr        = faddr(hslot_reg, pos_reg - CW'(1));
        in_stall       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    item_next = in_data;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    pend_next = 1'b0;
                    rec_raddr = '0;
                    if (in_data.operation)
                    begin
                        tick_next  = tick_reg + 8'd1;
                        state_next = S_TICK;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                    idx_next   = SCW'(1);
                    chk_next   = '0;
                    chk_v_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                // check record of chk_reg, read next slot
                if (chk_v_reg && !hit_reg && valid_reg[chk_s] && key_eq)
                begin
                    hit_next   = 1'b1;
                    hslot_next = chk_s;
                    hrec_next  = rec_rd;
                end
                if (chk_reg == SCW'(NUM_SLOTS - 1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    chk_next   = chk_reg + SCW'(1);
                    chk_v_next = 1'b1;
                    idx_next   = idx_reg + SCW'(1);
                end
            end
            S_DECIDE:
            begin
                if (hit_reg)
                begin
                    if (hcnt >= CW'(MAX_FRAGS))
                    begin
                        pend_item_next = '{EV_DROPPED, 6'(hslot_reg), 16'd0,
                                           {hrec_reg.hdr_words, 2'b00}, 1'b1};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        pos_next   = hcnt;
                        f_raddr    = faddr(hslot_reg, hcnt - CW'(1));
                        state_next = S_SHRD;
                    end
                end
                else
                begin
                    priority if (&valid_reg)
                    begin
                        pend_item_next = '{EV_DROPPED, 6'd0, 16'd0, 6'd0, 1'b1};
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        for (int s = NUM_SLOTS - 1; s >= 0; s--)
                        begin
                            if (!valid_reg[s])
                            begin
                                hslot_next = SW'(s);
                            end
                        end
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                // take a new slot
                rec_we    = 1'b1;
                rec_wdata = '{item_reg.src_addr, item_reg.dst_addr, item_reg.ident,
                              item_reg.header_words, tick_reg,
                              item_reg.frag_offset == 13'd0};
                valid_next[hslot_reg] = 1'b1;
                cnt_we   = 1'b1;
                cnt_wval = CW'(1);
                f_we     = 1'b1;
                f_waddr  = faddr(hslot_reg, '0);
                f_wdata  = '{item_reg.frag_offset, item_reg.more_fragments, plen};
                pend_item_next = '{EV_STORED, 6'(hslot_reg), 16'd0,
                                   {item_reg.header_words, 2'b00}, 1'b1};
                state_next = S_EMIT;
            end
            S_SHRD:
            begin
                // read of entry pos-1 issued; wait for the data
                if (pos_reg == '0)
                begin
                    state_next = S_SHWR;
                end
                else
                begin
                    f_raddr    = faddr(hslot_reg, pos_reg - CW'(1));
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                f_we = 1'b1;
                if (pos_reg != '0 && item_reg.frag_offset < f_rd.offset)
                begin
                    // shift entry pos-1 up, advance down
                    f_wdata    = f_rd;
                    pos_next   = pos_reg - CW'(1);
                    f_raddr    = faddr(hslot_reg, pos_reg - CW'(2));
                    state_next = S_SHRD;
                end
                else
                begin
                    f_wdata  = '{item_reg.frag_offset, item_reg.more_fragments, plen};
                    cnt_we   = 1'b1;
                    cnt_wval = hcnt + CW'(1);
                    n_next   = hcnt + CW'(1);
                    if (item_reg.frag_offset == 13'd0)
                    begin
                        hrec_next.hdr_words  = item_reg.header_words;
                        hrec_next.first_zero = 1'b1;
                        rec_we    = 1'b1;
                        rec_wdata = '{hrec_reg.src, hrec_reg.dst, hrec_reg.ident,
                                      item_reg.header_words, hrec_reg.start_tick, 1'b1};
                    end
                    wi_next    = '0;
                    run_next   = '0;
                    sum_next   = '0;
                    done_next  = 1'b0;
                    state_next = S_WALKRD;
                end
            end
            S_WALKRD:
            begin
                f_raddr    = faddr(hslot_reg, wi_reg);
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // sum every entry; judge contiguity until decided
                sum_next = sum_reg + f_rd.length;
                if (!done_reg)
                begin
                    if (run_reg != {f_rd.offset, 3'b000})
                    begin
                        done_next = 1'b1;
                    end
                    else if (!f_rd.more)
                    begin
                        done_next = 1'b1;
                        hit_next  = 1'b0; // hit cleared; pend_reg serves as complete flag below
                    end
                    run_next = run_reg + f_rd.length;
                end
                if (!done_reg && run_reg == {f_rd.offset, 3'b000} && !f_rd.more)
                begin
                    pend_next = 1'b1;
                end
                if (wi_reg + CW'(1) == n_reg)
                begin
                    if (pend_next)
                    begin
                        pend_item_next = '{EV_COMPLETE, 6'(hslot_reg),
                                           sum_reg + f_rd.length,
                                           {hrec_reg.hdr_words, 2'b00}, 1'b1};
                        valid_next[hslot_reg] = 1'b0;
                        cnt_we   = 1'b1;
                        cnt_wval = '0;
                    end
                    else
                    begin
                        pend_item_next = '{EV_STORED, 6'(hslot_reg), 16'd0,
                                           {hrec_reg.hdr_words, 2'b00}, 1'b1};
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    wi_next    = wi_reg + CW'(1);
                    f_raddr    = faddr(hslot_reg, wi_reg + CW'(1));
                    state_next = S_WALK;
                end
            end
            S_EMIT:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    out_next       = pend_item_reg;
                    out_valid_next = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_TICK:
            begin
                // rec_rd holds slot chk_reg; hold while a result waits
                if (chk_v_reg || !out_free)
                begin
                    if (!out_free && pend_reg)
                    begin
                        rec_raddr  = chk_s;
                        chk_v_next = 1'b1;
                    end
                    else
                    begin
                        if (valid_reg[chk_s]
                            && (tick_reg - rec_rd.start_tick) > timeout_reg)
                        begin
                            if (pend_reg)
                            begin
                                out_next       = pend_item_reg;
                                out_valid_next = 1'b1;
                            end
                            pend_next      = 1'b1;
                            pend_item_next = '{rec_rd.first_zero ? EV_TIME_EXCEEDED : EV_EXPIRED,
                                               6'(chk_s), 16'd0, {rec_rd.hdr_words, 2'b00},
                                               1'b0};
                            valid_next[chk_s] = 1'b0;
                            cnt_we    = 1'b1;
                            hslot_next = chk_s;
                        end
                        if (chk_reg == SCW'(NUM_SLOTS - 1))
                        begin
                            state_next = S_TEMIT;
                        end
                        else
                        begin
                            chk_next   = chk_reg + SCW'(1);
                            rec_raddr  = SW'(chk_reg + SCW'(1));
                            chk_v_next = 1'b1;
                        end
                    end
                end
                cnt_wval = '0;
                rec_waddr = chk_s;
            end
            S_TEMIT:
            begin
                if (!pend_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next       = pend_item_reg;
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // count write slot: tick clears the checked slot, others use the hit slot
    logic [SW-1:0] cnt_slot;
    assign cnt_slot = (state_reg == S_TICK) ? chk_s : hslot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            tick_reg      <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            chk_v_reg     <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                cnt_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            chk_v_reg     <= chk_v_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            if (cnt_we)
            begin
                cnt_reg[cnt_slot] <= cnt_wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        idx_reg       <= idx_next;
        chk_reg       <= chk_next;
        hit_reg       <= hit_next;
        hslot_reg     <= hslot_next;
        hrec_reg      <= hrec_next;
        pos_reg       <= pos_next;
        wi_reg        <= wi_next;
        run_reg       <= run_next;
        sum_reg       <= sum_next;
        done_reg      <= done_next;
        n_reg         <= n_next;
        pend_item_reg <= pend_item_next;
        out_reg       <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // no input accepted while a result is pending inside a tick
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> in_stall)
        else $error("input taken mid tick");
    // a fragment's single result always carries last
    a_frag_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !item_reg.operation |-> out_data.last)
        else $error("fragment result without last");
endmodule

/* rtl/ifrt_frag_mem.sv */
// Fragment list memory: one synchronous-read RAM holding every slot's sorted list.
`timescale 1ns / 1ps
module ifrt_frag_mem
    import ifrt_pkg::*;
#(
    parameter int DEPTH = 160,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  frag_t         wdata,
    input  logic [AW-1:0] raddr,
    output frag_t         rdata
);
    frag_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
